// ----- design/dpc_pkg.sv -----
// Shared types and constants for the dead pixel counter.
`default_nettype none
package dpc_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned RegW      = 13;
  localparam int unsigned RowW      = 12;
  localparam int unsigned RowLimit  = 4096;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CountOutW = 24;
  localparam int unsigned OutDepth  = 8;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned OutCntW   = OutPtrW + 1;
  localparam int unsigned MemDataW  = 2 * PixW;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 3'd0,
    RegImageHeight = 3'd1,
    RegLeft        = 3'd2,
    RegTop         = 3'd3,
    RegRight       = 3'd4,
    RegBottom      = 3'd5,
    RegGrayMode    = 3'd6,
    RegThreshold   = 3'd7
  } cfg_reg_e;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [7:0] nbr_t;

  // per-pixel control carried down the pipeline
  typedef struct packed {
    logic in_region;
    logic frame_end;
    logic region_ok;
  } side_t;

  typedef struct packed {
    logic                 region_ok;
    logic [PixW-1:0]      max_dev;
    logic [CountOutW-1:0] count;
  } result_t;

endpackage
`default_nettype wire

// ----- design/dpc_line_mem.sv -----
// Two-line luminance store: one read and one write port, registered read with forwarding.
`default_nettype none
module dpc_line_mem #(
  parameter int unsigned Depth = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(Depth)-1:0]     rd_addr_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(Depth)-1:0]     wr_addr_i,
  input  wire logic [dpc_pkg::MemDataW-1:0] wr_data_i,
  output logic      [dpc_pkg::MemDataW-1:0] rd_data_o
);

  logic [dpc_pkg::MemDataW-1:0] mem [Depth];
  logic [dpc_pkg::MemDataW-1:0] rd_q;
  logic [dpc_pkg::MemDataW-1:0] fwd_data_q;
  logic                         fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same entry written in the read cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

// ----- design/dpc_median8.sv -----
// Two-stage 19 compare-exchange merge network giving the upper median of 8 neighbors.
`default_nettype none
module dpc_median8 (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire dpc_pkg::nbr_t  nbr_i,
  input  wire dpc_pkg::pix_t  center_i,
  input  wire dpc_pkg::side_t side_i,
  output logic                valid_o,
  output dpc_pkg::pix_t       median_o,
  output dpc_pkg::pix_t       center_o,
  output dpc_pkg::side_t      side_o
);

  function automatic dpc_pkg::nbr_t cs(dpc_pkg::nbr_t v, logic [2:0] i, logic [2:0] j);
    dpc_pkg::nbr_t r;
    r = v;
    if (v[j] < v[i]) begin
      r[i] = v[j];
      r[j] = v[i];
    end
    return r;
  endfunction

  dpc_pkg::nbr_t  a_d, a_q, b_d;
  dpc_pkg::pix_t  center_a_q;
  dpc_pkg::side_t side_a_q;
  logic           valid_a_q;

  always_comb begin
    a_d = nbr_i;
    a_d = cs(a_d, 3'd0, 3'd1);
    a_d = cs(a_d, 3'd2, 3'd3);
    a_d = cs(a_d, 3'd4, 3'd5);
    a_d = cs(a_d, 3'd6, 3'd7);
    a_d = cs(a_d, 3'd0, 3'd2);
    a_d = cs(a_d, 3'd1, 3'd3);
    a_d = cs(a_d, 3'd4, 3'd6);
    a_d = cs(a_d, 3'd5, 3'd7);
    a_d = cs(a_d, 3'd1, 3'd2);
    a_d = cs(a_d, 3'd5, 3'd6);
  end

  always_comb begin
    b_d = a_q;
    b_d = cs(b_d, 3'd0, 3'd4);
    b_d = cs(b_d, 3'd1, 3'd5);
    b_d = cs(b_d, 3'd2, 3'd6);
    b_d = cs(b_d, 3'd3, 3'd7);
    b_d = cs(b_d, 3'd2, 3'd4);
    b_d = cs(b_d, 3'd3, 3'd5);
    b_d = cs(b_d, 3'd1, 3'd2);
    b_d = cs(b_d, 3'd3, 3'd4);
    b_d = cs(b_d, 3'd5, 3'd6);
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    center_a_q <= center_i;
    side_a_q   <= side_i;
    median_o   <= b_d[4];
    center_o   <= center_a_q;
    side_o     <= side_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_o   <= valid_a_q;
    end
  end

endmodule
`default_nettype wire

// ----- design/dpc_stats.sv -----
// Defect count and worst deviation per frame, with the result queue and its credit count.
`default_nettype none
module dpc_stats #(
  parameter int unsigned CountBits = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic                     flag_i,
  input  wire dpc_pkg::pix_t            dev_i,
  input  wire dpc_pkg::side_t           side_i,
  input  wire logic                     frame_start_i,
  output logic                          credit_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output dpc_pkg::result_t              out_result_o
);

  logic [CountBits-1:0]         cnt_q, cnt_new;
  dpc_pkg::pix_t                max_q, max_new;
  dpc_pkg::result_t             res_d;
  dpc_pkg::result_t             fifo_q [dpc_pkg::OutDepth];
  logic [dpc_pkg::OutPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dpc_pkg::OutCntW-1:0]  fill_q, pending_q;
  logic                         push, pop;

  assign cnt_new = (flag_i && !(&cnt_q)) ? cnt_q + 1'b1 : cnt_q;
  assign max_new = (flag_i && (dev_i > max_q)) ? dev_i : max_q;

  always_comb begin
    res_d.region_ok = side_i.region_ok;
    res_d.max_dev   = side_i.region_ok ? max_new : '0;
    res_d.count     = side_i.region_ok ? dpc_pkg::CountOutW'(cnt_new) : '0;
  end

  assign push = valid_i && side_i.frame_end;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      max_q <= '0;
    end else if (valid_i) begin
      if (side_i.frame_end) begin
        cnt_q <= '0;
        max_q <= '0;
      end else begin
        cnt_q <= cnt_new;
        max_q <= max_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
      pending_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      fill_q    <= fill_q + dpc_pkg::OutCntW'(push) - dpc_pkg::OutCntW'(pop);
      pending_q <= pending_q + dpc_pkg::OutCntW'(frame_start_i) - dpc_pkg::OutCntW'(pop);
    end
  end

  // pending counts results accepted but not yet taken, so the queue never overflows
  assign credit_o     = pending_q < dpc_pkg::OutCntW'(dpc_pkg::OutDepth);
  assign out_valid_o  = fill_q != '0;
  assign out_result_o = fifo_q[rd_ptr_q];

endmodule
`default_nettype wire

// ----- design/dead_pixel_counter_unit.sv -----
// Top level of the dead pixel counter: config, window pipeline, line store and statistics.
//
// Takes one pixel per clock in raster order while the result queue has credit: the line
// store is a single memory of MAX_LINE_WIDTH entries holding the two previous lines,
// read and rewritten once per pixel on separate ports. A frame's result is queued once its
// last pixel clears the window, median and threshold registers. Up to eight frame results
// queue at the output; input is held off only when that queue is committed in full.
// The line store needs no clearing after reset. Registers may be written whenever no
// pixel is in flight and take effect for the next pixel.
`default_nettype none
module dead_pixel_counter_unit #(
  parameter int unsigned MAX_LINE_WIDTH = 4096,
  parameter int unsigned COUNT_BITS     = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // chan_red, chan_green, chan_blue
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [31:0]                 m_axis_tdata,  // defect_count, max_deviation
  output logic                             m_axis_tuser,  // region_ok
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dpc_pkg::RegW-1:0]    cfg_data_i
);

  localparam int unsigned ColW  = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned CalcW = ((ColW > dpc_pkg::RegW) ? ColW : dpc_pkg::RegW) + 1;
  localparam logic [CalcW-1:0] MaxW = CalcW'(MAX_LINE_WIDTH);
  localparam logic [dpc_pkg::RegW-1:0] MaxH = dpc_pkg::RegW'(dpc_pkg::RowLimit);

  // configuration registers
  logic [dpc_pkg::RegW-1:0] width_q, height_q, left_q, top_q, right_q, bottom_q;
  logic                     gray_q;
  dpc_pkg::pix_t            thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dpc_pkg::RegW'(640);
      height_q <= dpc_pkg::RegW'(480);
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= dpc_pkg::RegW'(4096);
      bottom_q <= dpc_pkg::RegW'(4096);
      gray_q   <= 1'b0;
      thr_q    <= dpc_pkg::PixW'(40);
    end else if (cfg_valid_i) begin
      unique case (dpc_pkg::cfg_reg_e'(cfg_index_i))
        dpc_pkg::RegImageWidth:  width_q  <= cfg_data_i;
        dpc_pkg::RegImageHeight: height_q <= cfg_data_i;
        dpc_pkg::RegLeft:        left_q   <= cfg_data_i;
        dpc_pkg::RegTop:         top_q    <= cfg_data_i;
        dpc_pkg::RegRight:       right_q  <= cfg_data_i;
        dpc_pkg::RegBottom:      bottom_q <= cfg_data_i;
        dpc_pkg::RegGrayMode:    gray_q   <= cfg_data_i[0];
        dpc_pkg::RegThreshold:   thr_q    <= cfg_data_i[dpc_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [CalcW-1:0]         w_ext, w_cl, wm1, l_cl, r_cl, x_ext, cx;
  logic [dpc_pkg::RegW-1:0] h_cl, hm1, t_cl, b_cl, y_ext, cy;
  logic [ColW-1:0]          col_q;
  logic [dpc_pkg::RowW-1:0] row_q;
  logic                     line_end, frame_end, region_ok, in_region, accept;

  always_comb begin
    w_ext = CalcW'(width_q);
    if (w_ext == '0)       w_cl = CalcW'(1);
    else if (w_ext > MaxW) w_cl = MaxW;
    else                   w_cl = w_ext;
    wm1 = w_cl - 1'b1;

    if (height_q == '0)      h_cl = dpc_pkg::RegW'(1);
    else if (height_q > MaxH) h_cl = MaxH;
    else                      h_cl = height_q;
    hm1 = h_cl - 1'b1;

    l_cl = (left_q == '0) ? CalcW'(1) : CalcW'(left_q);
    r_cl = (CalcW'(right_q) > wm1) ? wm1 : CalcW'(right_q);
    t_cl = (top_q == '0) ? dpc_pkg::RegW'(1) : top_q;
    b_cl = (bottom_q > hm1) ? hm1 : bottom_q;

    region_ok = (l_cl < r_cl) && (t_cl < b_cl);

    x_ext = CalcW'(col_q);
    y_ext = dpc_pkg::RegW'(row_q);
    cx    = x_ext - 1'b1;
    cy    = y_ext - 1'b1;
    in_region = (col_q != '0) && (row_q != '0) && (cx >= l_cl) && (cx < r_cl)
                && (cy >= t_cl) && (cy < b_cl);

    line_end  = x_ext >= wm1;
    frame_end = line_end && (y_ext >= hm1);
  end

  // luminance: sum / 3 as multiply by 683 and shift by 11, exact for sums up to 765
  logic [9:0]    chan_sum;
  logic [20:0]   div_prod;
  dpc_pkg::pix_t lum;

  assign chan_sum = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                    + 10'(s_axis_tdata[23:16]);
  assign div_prod = 21'(chan_sum) * 21'd683;
  assign lum      = gray_q ? s_axis_tdata[7:0] : div_prod[18:11];

  logic credit;
  assign s_axis_tready = credit;
  assign accept        = s_axis_tvalid && credit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (line_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // stage 1: line store data returns, window shifts, store rewritten
  logic            v1_q;
  dpc_pkg::pix_t   lum1_q;
  logic [ColW-1:0] addr1_q;
  dpc_pkg::side_t  side1_q, side_in;

  always_comb begin
    side_in.in_region = in_region;
    side_in.frame_end = frame_end;
    side_in.region_ok = region_ok;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lum1_q  <= lum;
      addr1_q <= col_q;
      side1_q <= side_in;
    end
  end

  logic [dpc_pkg::MemDataW-1:0] mem_rd;
  dpc_pkg::pix_t                up_pix, mid_pix;

  assign up_pix  = mem_rd[dpc_pkg::MemDataW-1:dpc_pkg::PixW];
  assign mid_pix = mem_rd[dpc_pkg::PixW-1:0];

  dpc_line_mem #(
    .Depth(MAX_LINE_WIDTH)
  ) u_line_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i  (accept),
    .rd_addr_i(col_q),
    .wr_en_i  (v1_q),
    .wr_addr_i(addr1_q),
    .wr_data_i({mid_pix, lum1_q}),
    .rd_data_o(mem_rd)
  );

  // window rows: 0 upper, 1 middle, 2 current; columns: 2 newest
  dpc_pkg::pix_t [2:0][2:0] win_q;
  logic                     v2_q;
  dpc_pkg::side_t           side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      if (v1_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= up_pix;
        win_q[1][2] <= mid_pix;
        win_q[2][2] <= lum1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side1_q;
  end

  dpc_pkg::nbr_t nbr;
  always_comb begin
    nbr[0] = win_q[0][0];
    nbr[1] = win_q[0][1];
    nbr[2] = win_q[0][2];
    nbr[3] = win_q[1][0];
    nbr[4] = win_q[1][2];
    nbr[5] = win_q[2][0];
    nbr[6] = win_q[2][1];
    nbr[7] = win_q[2][2];
  end

  logic           med_valid;
  dpc_pkg::pix_t  med, med_center;
  dpc_pkg::side_t med_side;

  dpc_median8 u_median8 (
    .clk_i,
    .rst_ni,
    .valid_i (v2_q),
    .nbr_i   (nbr),
    .center_i(win_q[1][1]),
    .side_i  (side2_q),
    .valid_o (med_valid),
    .median_o(med),
    .center_o(med_center),
    .side_o  (med_side)
  );

  // deviation and threshold
  dpc_pkg::pix_t  dev_d, dev_q;
  logic           flag_q, v5_q;
  dpc_pkg::side_t side5_q;

  assign dev_d = (med_center > med) ? med_center - med : med - med_center;

  always_ff @(posedge clk_i) begin
    dev_q   <= dev_d;
    flag_q  <= med_side.in_region && (dev_d > thr_q);
    side5_q <= med_side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= med_valid;
    end
  end

  dpc_pkg::result_t result;

  dpc_stats #(
    .CountBits(COUNT_BITS)
  ) u_stats (
    .clk_i,
    .rst_ni,
    .valid_i      (v5_q),
    .flag_i       (flag_q),
    .dev_i        (dev_q),
    .side_i       (side5_q),
    .frame_start_i(accept && frame_end),
    .credit_o     (credit),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  assign m_axis_tdata = {result.max_dev, result.count};
  assign m_axis_tuser = result.region_ok;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for dead_pixel_counter_unit: streams frames, predicts and checks each frame result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineMax      = 4096;
  localparam int unsigned CountMax     = 24'hFFFFFF;
  localparam int unsigned RandomPixels = 2000;
  localparam int unsigned DrainCycles  = 20;
  localparam longint unsigned CycleLimit = 6_000_000;

  class defect_tally;
    logic [dpc_pkg::RegW-1:0] regs [8];
    bit [7:0] upper_line [LineMax];
    bit [7:0] middle_line [LineMax];
    bit [7:0] win [3][3];
    int unsigned col, row, flagged, worst;
    dpc_pkg::result_t due_results [$];
    int unsigned mismatches, frames_checked, pixels_taken;

    function new();
      regs[dpc_pkg::RegImageWidth]  = 640;
      regs[dpc_pkg::RegImageHeight] = 480;
      regs[dpc_pkg::RegLeft]        = 0;
      regs[dpc_pkg::RegTop]         = 0;
      regs[dpc_pkg::RegRight]       = 4096;
      regs[dpc_pkg::RegBottom]      = 4096;
      regs[dpc_pkg::RegGrayMode]    = 0;
      regs[dpc_pkg::RegThreshold]   = 40;
    endfunction

    function void set_reg(dpc_pkg::cfg_reg_e idx, logic [dpc_pkg::RegW-1:0] val);
      if (idx == dpc_pkg::RegGrayMode) begin
        regs[idx] = val & 13'h1;
      end else if (idx == dpc_pkg::RegThreshold) begin
        regs[idx] = val & 13'hFF;
      end else begin
        regs[idx] = val;
      end
    endfunction

    function int unsigned active_width();
      int unsigned w;
      w = regs[dpc_pkg::RegImageWidth];
      return (w < 1) ? 1 : (w > LineMax) ? LineMax : w;
    endfunction

    function int unsigned active_height();
      int unsigned h;
      h = regs[dpc_pkg::RegImageHeight];
      return (h < 1) ? 1 : (h > dpc_pkg::RowLimit) ? dpc_pkg::RowLimit : h;
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    function int unsigned pixels_left_in_frame();
      int unsigned w, h, here, rest;
      w = active_width();
      h = active_height();
      here = (col >= w - 1) ? 1 : w - col;
      rest = (row >= h - 1) ? 0 : (h - 1 - row) * w;
      return here + rest;
    endfunction

    function int unsigned pending_count();
      return due_results.size();
    endfunction

    function void take_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      int unsigned w, h, lft, top, rgt, bot, lum, x, y, med, ctr, dev;
      bit ok;
      bit [7:0] nbr [$];
      dpc_pkg::result_t res;
      w = active_width();
      h = active_height();
      lft = (regs[dpc_pkg::RegLeft] < 1) ? 1 : regs[dpc_pkg::RegLeft];
      top = (regs[dpc_pkg::RegTop] < 1) ? 1 : regs[dpc_pkg::RegTop];
      rgt = (regs[dpc_pkg::RegRight] > w - 1) ? w - 1 : regs[dpc_pkg::RegRight];
      bot = (regs[dpc_pkg::RegBottom] > h - 1) ? h - 1 : regs[dpc_pkg::RegBottom];
      ok = (lft < rgt) && (top < bot);
      lum = regs[dpc_pkg::RegGrayMode][0] ? int'(r) : (int'(r) + int'(g) + int'(b)) / 3;
      x = col % LineMax;
      y = row;
      pixels_taken++;

      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[x];
      win[1][2] = middle_line[x];
      win[2][2] = 8'(lum);
      upper_line[x] = middle_line[x];
      middle_line[x] = 8'(lum);

      if (x >= 1 && y >= 1 && x - 1 >= lft && x - 1 < rgt && y - 1 >= top && y - 1 < bot) begin
        nbr = '{win[0][0], win[0][1], win[0][2], win[1][0], win[1][2],
                win[2][0], win[2][1], win[2][2]};
        nbr.sort();
        med = nbr[4];  // upper median of the eight neighbors
        ctr = win[1][1];
        dev = (ctr > med) ? ctr - med : med - ctr;
        if (dev > regs[dpc_pkg::RegThreshold]) begin
          if (flagged < CountMax) flagged++;
          if (dev > worst) worst = dev;
        end
      end

      if (col >= w - 1) begin
        col = 0;
        if (row >= h - 1) begin
          row = 0;
          res.region_ok = ok;
          res.max_dev   = ok ? 8'(worst) : '0;
          res.count     = ok ? 24'(flagged) : '0;
          due_results.push_back(res);
          flagged = 0;
          worst = 0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [23:0] cnt, logic [7:0] peak, logic ok);
      dpc_pkg::result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: count %0d max %0d region_ok %0b",
                 $time, cnt, peak, ok);
        return;
      end
      want = due_results.pop_front();
      frames_checked++;
      if (cnt !== want.count) begin
        mismatches++;
        $display("%0t: defect_count expected %0d, got %0d", $time, want.count, cnt);
      end
      if (peak !== want.max_dev) begin
        mismatches++;
        $display("%0t: max_deviation expected %0d, got %0d", $time, want.max_dev, peak);
      end
      if (ok !== want.region_ok) begin
        mismatches++;
        $display("%0t: region_ok expected %0b, got %0b", $time, want.region_ok, ok);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  dpc_pkg::cfg_reg_e cfg_index_i = dpc_pkg::RegImageWidth;
  logic [dpc_pkg::RegW-1:0] cfg_data_i = '0;

  defect_tally tally = new();
  int unsigned idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned reg_writes = 0;
  int unsigned phases = 0;
  longint unsigned cycles = 0;

  dead_pixel_counter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("dead_pixel_counter_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tally.check_result(m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tuser);
    end
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom_range(9, 24);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned pick_start(int unsigned extent);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(0, 8191);
      2: return 8191;
      default: return $urandom_range(0, extent + 1);
    endcase
  endfunction

  function automatic int unsigned pick_end(int unsigned extent);
    case ($urandom_range(0, 7))
      0: return 4096;
      1: return $urandom_range(0, 8191);
      2: return 0;
      3: return 8191;
      default: return $urandom_range(0, extent + 1);
    endcase
  endfunction

  function automatic int unsigned pick_gray();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 1);
  endfunction

  function automatic int unsigned pick_threshold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 8191);
      3: return $urandom_range(0, 255);
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin : sink
    int unsigned stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic put_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    tally.take_pixel(r, g, b);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = pick_gap();
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_pixels(int unsigned total, bit smooth);
    int unsigned base;
    bit [7:0] r, g, b;
    base = $urandom_range(16, 239);
    repeat (total) begin
      if (!smooth) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end else if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = r;
        b = r;
      end else begin
        r = 8'(base + $urandom_range(0, 6) - 3);
        g = 8'(base + $urandom_range(0, 6) - 3);
        b = 8'(base + $urandom_range(0, 6) - 3);
      end
      put_pixel(r, g, b);
    end
    drop_valid();
  endtask

  task automatic write_reg(dpc_pkg::cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 13'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    tally.set_reg(idx, 13'(val));
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_regs(int unsigned w, int unsigned h, int unsigned lft, int unsigned top,
                           int unsigned rgt, int unsigned bot, int unsigned gray,
                           int unsigned thr);
    write_reg(dpc_pkg::RegImageWidth, w);
    write_reg(dpc_pkg::RegImageHeight, h);
    write_reg(dpc_pkg::RegLeft, lft);
    write_reg(dpc_pkg::RegTop, top);
    write_reg(dpc_pkg::RegRight, rgt);
    write_reg(dpc_pkg::RegBottom, bot);
    write_reg(dpc_pkg::RegGrayMode, gray);
    write_reg(dpc_pkg::RegThreshold, thr);
  endtask

  // wait for all frame results, then let any pixel still in the pipe drain
  task automatic settle();
    while (tally.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_items, n, w, h;
    int unsigned ext_w [4];
    int unsigned ext_h [4];
    ext_w = '{0, 3, 1, 2};
    ext_h = '{3, 0, 2, 1};
    random_items = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // hot pixel in gray mode, chroma ignored
    load_regs(3, 3, 0, 0, 4096, 4096, 1, 0);
    for (int k = 0; k < 9; k++) put_pixel((k == 4) ? 8'd250 : 8'd10, 8'($urandom), 8'($urandom));
    drop_valid();
    settle();

    // dead pixel with three-channel average, truncating sums
    write_reg(dpc_pkg::RegGrayMode, 0);
    write_reg(dpc_pkg::RegThreshold, 253);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) put_pixel(8'd0, 8'd0, 8'd1);
      else put_pixel(8'd255, 8'd255, 8'd254);
    end
    drop_valid();
    settle();

    // single pixel frame: empty region
    write_reg(dpc_pkg::RegImageWidth, 1);
    write_reg(dpc_pkg::RegImageHeight, 1);
    put_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    drop_valid();
    settle();

    // size extremes and clamps
    foreach (ext_w[i]) begin
      idle_pct = pick_idle();
      load_regs(ext_w[i], ext_h[i], $urandom_range(0, 2), $urandom_range(0, 2), 8191, 8191,
                $urandom_range(0, 1), $urandom_range(0, 40));
      send_pixels(tally.pixels_left_in_frame(), 1'($urandom_range(0, 1)));
      settle();
      phases++;
    end

    // output held off long enough for the result queue to fill and stall input
    load_regs(3, 3, 0, 0, 4096, 4096, $urandom_range(0, 1), 20);
    idle_pct = 0;
    hold_request = 300;
    send_pixels(117, 1'b0);
    settle();
    phases++;

    while (random_items < RandomPixels) begin
      idle_pct = pick_idle();
      if (tally.at_frame_start()) begin
        w = pick_size();
        h = pick_size();
        load_regs(w, h, pick_start(w), pick_start(h), pick_end(w), pick_end(h),
                  pick_gray(), pick_threshold());
      end else begin
        // mid-frame: width may only shrink
        w = tally.active_width();
        h = tally.active_height();
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegImageWidth, $urandom_range(0, w));
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegImageHeight, pick_size());
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegLeft, pick_start(w));
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegTop, pick_start(h));
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegRight, pick_end(w));
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegBottom, pick_end(h));
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegGrayMode, pick_gray());
        if ($urandom_range(0, 2) == 0) write_reg(dpc_pkg::RegThreshold, pick_threshold());
      end
      n = tally.pixels_left_in_frame();
      if ($urandom_range(0, 4) == 0 && n > 1) begin
        n = $urandom_range(1, n - 1);
      end else begin
        n += $urandom_range(0, 2) * tally.active_width() * tally.active_height();
      end
      send_pixels(n, 1'($urandom_range(0, 4) >= 2));
      random_items += n;
      phases++;
      settle();
    end

    settle();
    $display("Streamed %0d pixels in %0d phases with %0d register writes;",
             tally.pixels_taken, phases, reg_writes);
    $display("%0d frame results checked.", tally.frames_checked);
    $display("Covered size clamps, empty regions, mid-frame register changes and output backpressure.");
    if (tally.mismatches == 0 && tally.pending_count() == 0) begin
      $display("dead_pixel_counter_unit regression: pass");
    end else begin
      $display("dead_pixel_counter_unit regression: fail");
    end
    $finish;
  end

endmodule
